### rtl/gbgc_pkg.sv
// ----------------------------------------------------------------------------
// gbgc_pkg
// Types, constants and helper functions shared by the ground classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package gbgc_pkg;

  localparam int DEF_GRID_ROWS = 128;
  localparam int DEF_GRID_COLS = 128;

  // Quotient bits of (offset << 16) / spacing: 32 cell bits and 16 residual bits.
  localparam int DIV_STEPS   = 48;
  localparam int ADDR_MAX_W  = 22;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_ROW_SPACING  = 3'd2,
    REG_COL_SPACING  = 3'd3,
    REG_TOLERANCE    = 3'd4
  } gbgc_reg_e;

  typedef enum logic {
    MODE_WRITE    = 1'b0,
    MODE_CLASSIFY = 1'b1
  } gbgc_mode_e;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic        [23:0] row_spacing;
    logic        [23:0] col_spacing;
    logic        [23:0] tolerance;
  } gbgc_cfg_t;

  typedef struct packed {
    logic               mode;
    logic        [6:0]  cell_row;
    logic        [6:0]  cell_col;
    logic signed [23:0] cell_height;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [23:0] point_z;
  } gbgc_in_t;

  typedef struct packed {
    logic [23:0] rem;
    logic [47:0] work;
  } gbgc_div_t;

  typedef struct packed {
    logic               is_write;
    logic               neg;
    logic        [6:0]  cell_row;
    logic        [6:0]  cell_col;
    logic signed [23:0] height;
    logic signed [23:0] pz;
    gbgc_div_t          xd;
    gbgc_div_t          yd;
  } gbgc_fst_t;

  typedef struct packed {
    logic                             is_write;
    logic                             wr_en;
    logic                             outside;
    logic [1:0]                       wbank;
    logic                             par_r;
    logic                             par_c;
    logic [3:0][ADDR_MAX_W-1:0]       addr;
    logic [15:0]                      rx;
    logic [15:0]                      ry;
    logic signed [23:0]               pz;
    logic signed [23:0]               height;
  } gbgc_cmd_t;

  // One restoring division step: shifts in the next dividend bit, emits a quotient bit.
  function automatic gbgc_div_t gbgc_div_step(gbgc_div_t d, logic [23:0] dv);
    logic [24:0] t;
    gbgc_div_t   r;
    t = {d.rem, d.work[47]};
    if (t >= {1'b0, dv}) begin
      r.rem  = 24'(t - {1'b0, dv});
      r.work = {d.work[46:0], 1'b1};
    end else begin
      r.rem  = t[23:0];
      r.work = {d.work[46:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/gbgc_front.sv
// ----------------------------------------------------------------------------
// gbgc_front
// Accepts items, forms grid offsets and runs a pipelined long division that
// yields cell indices, residuals and bank addresses for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gbgc_front #(
  parameter int GRID_ROWS = gbgc_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = gbgc_pkg::DEF_GRID_COLS
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  gbgc_pkg::gbgc_cfg_t  cfg_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  gbgc_pkg::gbgc_in_t   in_item_i,
  input  wire                  q_full_i,
  output logic                 q_push_o,
  output gbgc_pkg::gbgc_cmd_t  q_cmd_o
);

  localparam int NST = gbgc_pkg::DIV_STEPS;
  localparam int HC  = (GRID_COLS + 1) / 2;

  logic                adv;
  logic [NST:0]        vld_q;
  gbgc_pkg::gbgc_fst_t st_q [NST+1];
  gbgc_pkg::gbgc_fst_t st_d [NST+1];
  logic signed [32:0]  dx, dy;
  logic [31:0]         row32, col32, wr_row32, wr_col32;
  gbgc_pkg::gbgc_fst_t last;

  function automatic logic [gbgc_pkg::ADDR_MAX_W-1:0] bank_addr(logic [31:0] r,
                                                                 logic [31:0] c);
    return gbgc_pkg::ADDR_MAX_W'((r >> 1) * 32'(HC) + (c >> 1));
  endfunction

  assign adv        = !q_full_i;
  assign in_ready_o = adv;

  always_comb begin
    dx = {in_item_i.point_x[31], in_item_i.point_x} - {cfg_i.origin_x[31], cfg_i.origin_x};
    dy = {in_item_i.point_y[31], in_item_i.point_y} - {cfg_i.origin_y[31], cfg_i.origin_y};
    st_d[0].is_write = (in_item_i.mode == gbgc_pkg::MODE_WRITE);
    st_d[0].neg      = dx[32] | dy[32];
    st_d[0].cell_row = in_item_i.cell_row;
    st_d[0].cell_col = in_item_i.cell_col;
    st_d[0].height   = in_item_i.cell_height;
    st_d[0].pz       = in_item_i.point_z;
    st_d[0].xd.rem   = '0;
    st_d[0].xd.work  = {dx[31:0], 16'h0000};
    st_d[0].yd.rem   = '0;
    st_d[0].yd.work  = {dy[31:0], 16'h0000};
  end

  for (genvar k = 1; k <= NST; k++) begin : g_div
    always_comb begin
      st_d[k]    = st_q[k-1];
      st_d[k].xd = gbgc_pkg::gbgc_div_step(st_q[k-1].xd, cfg_i.row_spacing);
      st_d[k].yd = gbgc_pkg::gbgc_div_step(st_q[k-1].yd, cfg_i.col_spacing);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= NST; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    last     = st_q[NST];
    row32    = last.xd.work[47:16];
    col32    = last.yd.work[47:16];
    wr_row32 = 32'(last.cell_row);
    wr_col32 = 32'(last.cell_col);
    q_push_o = vld_q[NST] && adv;

    q_cmd_o.is_write = last.is_write;
    q_cmd_o.wr_en    = (wr_row32 < 32'(GRID_ROWS)) && (wr_col32 < 32'(GRID_COLS));
    q_cmd_o.outside  = last.neg || (row32 >= 32'(GRID_ROWS - 1))
                       || (col32 >= 32'(GRID_COLS - 1));
    q_cmd_o.rx       = last.xd.work[15:0];
    q_cmd_o.ry       = last.yd.work[15:0];
    q_cmd_o.pz       = last.pz;
    q_cmd_o.height   = last.height;
    if (last.is_write) begin
      q_cmd_o.wbank = {wr_row32[0], wr_col32[0]};
      q_cmd_o.par_r = wr_row32[0];
      q_cmd_o.par_c = wr_col32[0];
      for (int b = 0; b < 4; b++) begin
        q_cmd_o.addr[b] = bank_addr(wr_row32, wr_col32);
      end
    end else begin
      q_cmd_o.wbank = '0;
      q_cmd_o.par_r = row32[0];
      q_cmd_o.par_c = col32[0];
      for (int b = 0; b < 4; b++) begin
        q_cmd_o.addr[b] = bank_addr(row32 + 32'(row32[0] ^ b[1]),
                                    col32 + 32'(col32[0] ^ b[0]));
      end
    end
  end

endmodule

`default_nettype wire

### rtl/gbgc_queue.sv
// ----------------------------------------------------------------------------
// gbgc_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gbgc_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  gbgc_pkg::gbgc_cmd_t  push_cmd_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 empty_o,
  output gbgc_pkg::gbgc_cmd_t  pop_cmd_o
);

  gbgc_pkg::gbgc_cmd_t              buf_q [gbgc_pkg::QUEUE_DEPTH];
  logic [gbgc_pkg::QPTR_W-1:0]      wp_q, rp_q;
  logic [gbgc_pkg::QCNT_W-1:0]      cnt_q, cnt_d;

  assign full_o    = (cnt_q == gbgc_pkg::QCNT_W'(gbgc_pkg::QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = buf_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= push_cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= gbgc_pkg::QCNT_W'(gbgc_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

`default_nettype wire

### rtl/gbgc_back.sv
// ----------------------------------------------------------------------------
// gbgc_back
// Holds the height grid in four parity banks, performs writes, reads the four
// corners, interpolates, compares with the tolerance and registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module gbgc_back #(
  parameter int GRID_ROWS = gbgc_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = gbgc_pkg::DEF_GRID_COLS
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [23:0]           tolerance_i,
  input  wire                  q_empty_i,
  output logic                 q_pop_o,
  input  gbgc_pkg::gbgc_cmd_t  q_cmd_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic                 out_ground_o,
  output logic                 out_outside_o,
  output logic signed [23:0]   out_surface_o,
  output logic [23:0]          out_gap_o
);

  localparam int HR  = (GRID_ROWS + 1) / 2;
  localparam int HC  = (GRID_COLS + 1) / 2;
  localparam int BD  = HR * HC;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

  logic               be;
  logic               v1_q, v2_q, v3_q, v4_q, ov_q;
  logic signed [23:0] rd_q [4];
  logic               o1_q, o2_q, o3_q, o4_q;
  logic               pr_q, pc_q;
  logic [15:0]        rx1_q, ry1_q, ry2_q;
  logic signed [23:0] pz1_q, pz2_q, pz3_q, pz4_q;
  logic signed [42:0] a_q, b_q, a_d, b_d;
  logic signed [59:0] s_q, s_d, rnd;
  logic signed [23:0] surf_q;
  logic signed [23:0] h00, h10, h01, h11;
  logic [16:0]        wx0, wy0;
  logic signed [24:0] gap_s;
  logic [24:0]        gap_m;
  logic [23:0]        gap24;

  assign be      = !ov_q || out_ready_i;
  assign q_pop_o = be && !q_empty_i;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic signed [23:0] mem [BD];
    always_ff @(posedge clk_i) begin
      if (q_pop_o && q_cmd_i.is_write && q_cmd_i.wr_en && (q_cmd_i.wbank == 2'(b))) begin
        mem[q_cmd_i.addr[b][BAW-1:0]] <= q_cmd_i.height;
      end
      if (q_pop_o) begin
        rd_q[b] <= mem[q_cmd_i.addr[b][BAW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (be) begin
      v1_q <= q_pop_o && !q_cmd_i.is_write;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      ov_q <= v4_q;
    end
  end

  always_comb begin
    h00 = rd_q[{pr_q, pc_q}];
    h10 = rd_q[{~pr_q, pc_q}];
    h01 = rd_q[{pr_q, ~pc_q}];
    h11 = rd_q[{~pr_q, ~pc_q}];
    wx0 = 17'h10000 - {1'b0, rx1_q};
    wy0 = 17'h10000 - {1'b0, ry2_q};
    a_d = {{19{h00[23]}}, h00} * $signed({26'd0, wx0})
        + {{19{h10[23]}}, h10} * $signed({27'd0, rx1_q});
    b_d = {{19{h01[23]}}, h01} * $signed({26'd0, wx0})
        + {{19{h11[23]}}, h11} * $signed({27'd0, rx1_q});
    s_d = {{17{a_q[42]}}, a_q} * $signed({43'd0, wy0})
        + {{17{b_q[42]}}, b_q} * $signed({44'd0, ry2_q});
    rnd = s_q + 60'sh0_0000_0080_0000_00;
    gap_s = {pz4_q[23], pz4_q} - {surf_q[23], surf_q};
    gap_m = gap_s[24] ? 25'(-gap_s) : gap_s;
    gap24 = gap_m[24] ? 24'hFFFFFF : gap_m[23:0];
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      o1_q  <= q_cmd_i.outside;
      pr_q  <= q_cmd_i.par_r;
      pc_q  <= q_cmd_i.par_c;
      rx1_q <= q_cmd_i.rx;
      ry1_q <= q_cmd_i.ry;
      pz1_q <= q_cmd_i.pz;

      a_q   <= a_d;
      b_q   <= b_d;
      ry2_q <= ry1_q;
      o2_q  <= o1_q;
      pz2_q <= pz1_q;

      s_q   <= s_d;
      o3_q  <= o2_q;
      pz3_q <= pz2_q;

      surf_q <= rnd[55:32];
      o4_q   <= o3_q;
      pz4_q  <= pz3_q;

      if (o4_q) begin
        out_ground_o  <= 1'b0;
        out_outside_o <= 1'b1;
        out_surface_o <= '0;
        out_gap_o     <= '0;
      end else begin
        out_ground_o  <= gap24 < tolerance_i;
        out_outside_o <= 1'b0;
        out_surface_o <= surf_q;
        out_gap_o     <= gap24;
      end
    end
  end

  assign out_valid_o = ov_q;

  a_outside_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_outside_o) |-> (!out_ground_o && out_surface_o == '0 && out_gap_o == '0))
    else $error("outside result carries data");

  a_pop_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |-> !q_pop_o)
    else $error("command taken while result stalled");

  a_ground_below_tol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_ground_o) |-> (out_gap_o < tolerance_i))
    else $error("ground flag disagrees with gap");

endmodule

`default_nettype wire

### rtl/grid_bilinear_ground_classifier.sv
// ----------------------------------------------------------------------------
// grid_bilinear_ground_classifier
// Classifies points as ground against a bilinearly interpolated height grid.
//
// Input items arrive on the s_axis stream; tuser selects a height write (0)
// or a point classification (1). Writes load one grid cell and give no
// result; each classification gives one result item on m_axis. The APB port
// sets the origin, the cell spacings and the ground tolerance; the user must
// write them only while idle, the block itself does not enforce it. One item
// is accepted per cycle while the queue is not full. A point passes one
// offset stage, 48 stages of the long division that yields cell and residual,
// the command queue and five stages of grid read, interpolation and compare.
// Writes take the same path, so grid updates and reads keep their order.
// Reset clears the pipeline, the queue and the registers; grid contents stay
// undefined until written. When the receiver stalls, the output holds, the
// back end waits, the four-entry queue fills and then s_axis_tready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_bilinear_ground_classifier #(
  parameter int GRID_ROWS = gbgc_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = gbgc_pkg::DEF_GRID_COLS
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_row, cell_col, cell_height, point_x, point_y, point_z, zero pad
  input  wire [127:0]  s_axis_tdata,
  // mode
  input  wire          s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // is_ground, outside_grid, surface_height, height_gap, zero pad
  output logic [55:0]  m_axis_tdata,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire [4:0]    paddr,
  input  wire [31:0]   pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  gbgc_pkg::gbgc_cfg_t  cfg_q, cfg_eff;
  gbgc_pkg::gbgc_in_t   in_item;
  gbgc_pkg::gbgc_cmd_t  push_cmd, pop_cmd;
  gbgc_pkg::gbgc_reg_e  reg_sel;
  logic                 q_push, q_pop, q_full, q_empty;
  logic                 o_ground, o_outside;
  logic signed [23:0]   o_surface;
  logic [23:0]          o_gap;

  assign pready  = 1'b1;
  assign reg_sel = gbgc_pkg::gbgc_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x    <= '0;
      cfg_q.origin_y    <= '0;
      cfg_q.row_spacing <= 24'd256;
      cfg_q.col_spacing <= 24'd256;
      cfg_q.tolerance   <= 24'd128;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        gbgc_pkg::REG_ORIGIN_X:    cfg_q.origin_x    <= pwdata;
        gbgc_pkg::REG_ORIGIN_Y:    cfg_q.origin_y    <= pwdata;
        gbgc_pkg::REG_ROW_SPACING: cfg_q.row_spacing <= pwdata[23:0];
        gbgc_pkg::REG_COL_SPACING: cfg_q.col_spacing <= pwdata[23:0];
        gbgc_pkg::REG_TOLERANCE:   cfg_q.tolerance   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gbgc_pkg::REG_ORIGIN_X:    prdata = cfg_q.origin_x;
      gbgc_pkg::REG_ORIGIN_Y:    prdata = cfg_q.origin_y;
      gbgc_pkg::REG_ROW_SPACING: prdata = {8'h00, cfg_q.row_spacing};
      gbgc_pkg::REG_COL_SPACING: prdata = {8'h00, cfg_q.col_spacing};
      gbgc_pkg::REG_TOLERANCE:   prdata = {8'h00, cfg_q.tolerance};
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg_eff = cfg_q;
    if (cfg_q.row_spacing == '0) begin
      cfg_eff.row_spacing = 24'd1;
    end
    if (cfg_q.col_spacing == '0) begin
      cfg_eff.col_spacing = 24'd1;
    end
    in_item.mode        = s_axis_tuser;
    in_item.cell_row    = s_axis_tdata[6:0];
    in_item.cell_col    = s_axis_tdata[13:7];
    in_item.cell_height = s_axis_tdata[37:14];
    in_item.point_x     = s_axis_tdata[69:38];
    in_item.point_y     = s_axis_tdata[101:70];
    in_item.point_z     = s_axis_tdata[125:102];
  end

  gbgc_front #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_eff),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  gbgc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  gbgc_back #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tolerance_i   (cfg_q.tolerance),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .q_cmd_i       (pop_cmd),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_ground_o  (o_ground),
    .out_outside_o (o_outside),
    .out_surface_o (o_surface),
    .out_gap_o     (o_gap)
  );

  assign m_axis_tdata = {6'b000000, o_gap, o_surface, o_outside, o_ground};

endmodule

`default_nettype wire
